FILE: rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Shared widths, register indexes and the payload types of both channels.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 16;
  localparam int HdrW    = 24;
  localparam int HdrCntW = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = LenW;

  // Number of header bytes before the final one.
  localparam logic [HdrCntW-1:0] HdrLastCnt = HdrCntW'(3);

  localparam logic [ByteW-1:0] SkipByteRst = 8'h00;
  localparam logic [LenW-1:0]  MaxLenRst   = 16'd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SKIP_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LEN   = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  byte_offset;
    logic [LenW-1:0]  frame_length;
    logic             last_of_frame;
  } out_item_t;

endpackage

FILE: rtl/lpfd_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface lpfd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/length_prefixed_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Strips 4-byte big-endian length headers and passes payload bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one received byte per transaction. out_chan carries one
//   payload byte per transaction with its offset, the frame length and a
//   last-of-frame flag. Header bytes, skip bytes seen while idle and
//   rejected headers produce no output transaction.
//   The cfg port writes the idle skip byte (index 0) or the maximum frame
//   length (index 1); write only while no transaction is in flight.
// Timing:
//   A byte is registered at its input transaction, processed from the input
//   register and its result is registered in the result register, which
//   drives the output transaction. One byte is accepted every cycle while
//   out_chan does not stall.
// Reset and stall:
//   Reset (rst_n low, synchronous) returns the block to idle with no header
//   bytes held and restores the register defaults. When out_chan stalls the
//   result register holds its item and in_ready drops once the processing
//   stage is also occupied; no byte is lost.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_top
  import lpfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  lpfd_stream_if.sink         in_chan,
  lpfd_stream_if.source       out_chan,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic [ByteW-1:0] skip_byte_r;
  logic [LenW-1:0]  max_len_r;

  // Input stage.
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;

  // Deframer state.
  logic [HdrCntW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [HdrW-1:0]    hdr_bytes_r, hdr_bytes_nxt;
  logic [LenW-1:0]    exp_len_r, exp_len_nxt;
  logic [LenW-1:0]    rcv_cnt_r, rcv_cnt_nxt;

  // Result register.
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      res_nxt;

  logic      s1_adv;
  logic      in_xfer;
  logic [LenW:0] rcv_inc;
  logic [LenW+HdrW-ByteW-1:0] hdr_len;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_byte_r <= SkipByteRst;
      max_len_r   <= MaxLenRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_BYTE: skip_byte_r <= cfg_data[ByteW-1:0];
        REG_MAX_LEN:   max_len_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_chan.data.data_byte;
    end
  end

  // Header collection, length check and payload numbering.
  assign rcv_inc = {1'b0, rcv_cnt_r} + (LenW+1)'(1);
  assign hdr_len = {hdr_bytes_r, s1_byte_r};

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_bytes_nxt = hdr_bytes_r;
    exp_len_nxt   = exp_len_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    res_nxt       = 1'b0;
    out_item_nxt.payload_byte  = s1_byte_r;
    out_item_nxt.byte_offset   = rcv_cnt_r;
    out_item_nxt.frame_length  = exp_len_r;
    out_item_nxt.last_of_frame = (rcv_inc >= {1'b0, exp_len_r});
    if (exp_len_r == '0) begin
      if (hdr_cnt_r == '0 && s1_byte_r == skip_byte_r) begin
        rcv_cnt_nxt = '0;
      end else if (hdr_cnt_r != HdrLastCnt) begin
        hdr_bytes_nxt = {hdr_bytes_r[HdrW-ByteW-1:0], s1_byte_r};
        hdr_cnt_nxt   = hdr_cnt_r + HdrCntW'(1);
      end else begin
        hdr_cnt_nxt   = '0;
        hdr_bytes_nxt = '0;
        rcv_cnt_nxt   = '0;
        if (hdr_len[LenW+HdrW-ByteW-1:LenW] != '0 || hdr_len[LenW-1:0] == '0 ||
            hdr_len[LenW-1:0] > max_len_r) begin
          exp_len_nxt = '0;
        end else begin
          exp_len_nxt = hdr_len[LenW-1:0];
        end
      end
    end else begin
      res_nxt = 1'b1;
      if (out_item_nxt.last_of_frame) begin
        exp_len_nxt = '0;
        rcv_cnt_nxt = '0;
      end else begin
        rcv_cnt_nxt = rcv_inc[LenW-1:0];
      end
    end
  end

  // State update, one byte per advance of the processing stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      hdr_bytes_r <= '0;
      exp_len_r   <= '0;
      rcv_cnt_r   <= '0;
    end else if (s1_adv) begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      hdr_bytes_r <= hdr_bytes_nxt;
      exp_len_r   <= exp_len_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
    end
  end

  // Result register; a waiting result holds until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_nxt;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef SYNTHESIS
  // A delivered byte always lies inside its frame.
  a_offset_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.byte_offset < out_item_r.frame_length)
    else $error("byte offset outside frame");

  // The last byte of a frame sits at offset length minus one.
  a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_of_frame) |->
      (out_item_r.byte_offset + LenW'(1) == out_item_r.frame_length))
    else $error("last byte at wrong offset");

  // No header bytes are held while a frame is open.
  a_no_hdr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r != '0) |-> (hdr_cnt_r == '0))
    else $error("header count nonzero inside frame");

  // The payload counter stays below the frame length.
  a_rcv_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r != '0) |-> (rcv_cnt_r < exp_len_r))
    else $error("payload count reached frame length");
`endif

endmodule
